FILE: rtl/jsc_pkg.sv
// Shared types, constants and literal tables for the JSON syntax checker.
// No dependencies.
`timescale 1ns / 1ps
package jsc_pkg;

  localparam int MAX_DEPTH    = 64;
  localparam int OFFSET_WIDTH = 16;
  localparam int DEPTH_W      = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [3:0] E_OK       = 4'd0;
  localparam logic [3:0] E_ROOT     = 4'd1;
  localparam logic [3:0] E_EARLY    = 4'd2;
  localparam logic [3:0] E_KEY      = 4'd3;
  localparam logic [3:0] E_COLON    = 4'd4;
  localparam logic [3:0] E_NOVAL    = 4'd5;
  localparam logic [3:0] E_SEP      = 4'd6;
  localparam logic [3:0] E_TRAIL    = 4'd7;
  localparam logic [3:0] E_ESCAPE   = 4'd8;
  localparam logic [3:0] E_CONTROL  = 4'd9;
  localparam logic [3:0] E_LITERAL  = 4'd10;
  localparam logic [3:0] E_NUMBER   = 4'd11;
  localparam logic [3:0] E_CHAR     = 4'd12;
  localparam logic [3:0] E_AFTER    = 4'd13;
  localparam logic [3:0] E_DEPTH    = 4'd14;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  typedef enum logic [4:0] {
    M_ROOT, M_OBJ_OPEN, M_OBJ_COMMA, M_KEY_STR, M_KEY_ESC, M_OBJ_COLON,
    M_OBJ_VALUE, M_OBJ_AFTER, M_ARR_OPEN, M_ARR_COMMA, M_ARR_AFTER,
    M_VAL_STR, M_VAL_ESC, M_LIT, M_NUM_SIGN, M_NUM_INT, M_NUM_DOT,
    M_NUM_FRAC, M_NUM_EXP, M_NUM_EXPSIGN, M_NUM_EXPDIG, M_AFTER_ROOT, M_ERR
  } mode_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic kind;
  } stack_op_t;

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    case (kind)
      LIT_FALSE: lit_len = 3'd5;
      default:   lit_len = 3'd4;
    endcase
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [39:0] txt;
    case (kind)
      LIT_FALSE: txt = {8'h65, 8'h73, 8'h6C, 8'h61, 8'h66};
      LIT_NULL:  txt = {8'h00, 8'h6C, 8'h6C, 8'h75, 8'h6E};
      default:   txt = {8'h00, 8'h65, 8'h75, 8'h72, 8'h74};
    endcase
    case (idx)
      3'd0:    lit_char = txt[7:0];
      3'd1:    lit_char = txt[15:8];
      3'd2:    lit_char = txt[23:16];
      3'd3:    lit_char = txt[31:24];
      3'd4:    lit_char = txt[39:32];
      default: lit_char = 8'h00;
    endcase
  endfunction

endpackage

FILE: rtl/jsc_stack.sv
// Nesting stack: the top entry in a register, all entries in a synchronous memory.
// Depends on jsc_pkg.
`timescale 1ns / 1ps
module jsc_stack (
  input  logic                       clk,
  input  logic                       rst_n,
  input  jsc_pkg::stack_op_t         op,
  output logic [jsc_pkg::DEPTH_W-1:0] depth,
  output logic                       top,
  output logic                       below
);

  logic                        mem [jsc_pkg::MAX_DEPTH];
  logic [jsc_pkg::DEPTH_W-1:0] depth_r;
  logic [jsc_pkg::DEPTH_W-1:0] depth_nxt;
  logic [jsc_pkg::DEPTH_W-1:0] rd_ptr;
  logic                        top_r;
  logic                        rd_q_r;

  // The memory is read every cycle at the entry just under the next top,
  // so a pop always finds the new top waiting in the read register.
  always_comb begin
    depth_nxt = depth_r;
    if (op.clear) begin
      depth_nxt = '0;
    end else if (op.push) begin
      depth_nxt = depth_r + 1'b1;
    end else if (op.pop) begin
      depth_nxt = depth_r - 1'b1;
    end
    rd_ptr = depth_nxt - jsc_pkg::DEPTH_W'(2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[depth_r[jsc_pkg::ADDR_W-1:0]] <= op.kind;
      top_r <= op.kind;
    end else if (op.pop) begin
      top_r <= rd_q_r;
    end
    rd_q_r <= mem[rd_ptr[jsc_pkg::ADDR_W-1:0]];
  end

  assign depth = depth_r;
  assign top   = top_r;
  assign below = rd_q_r;

endmodule

FILE: rtl/json_syntax_checker.sv
// Top level of the streaming JSON syntax checker: parser state, error latch, result register.
// Depends on jsc_pkg and jsc_stack.
//
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------------------------------
//  input   | in_tvalid/in_tready/in_tlast   | tdata[7:0] data_byte, tlast last_byte
//  result  | out_tvalid/out_tready          | tdata[0] is_valid, [4:1] code, [20:5] offset
//
// One byte is taken every cycle while in_tready is high; the parser decides each byte
// combinationally. The nesting stack memory is read ahead so a pop needs no wait.
// A verdict appears the cycle after the last byte is taken; input stalls only while a
// verdict waits and out_tready is low. Reset is synchronous and clears all control state.
`timescale 1ns / 1ps
module json_syntax_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // is_valid, error_code, error_offset, zero pad
);

  localparam logic [jsc_pkg::OFFSET_WIDTH-1:0] OFF_MAX = '1;

  jsc_pkg::mode_t                     mode_r, mode_nxt, eff;
  logic [1:0]                         kind_r, kind_nxt;
  logic [2:0]                         idx_r, idx_nxt;
  logic [3:0]                         err_r, err_nxt;
  logic [jsc_pkg::OFFSET_WIDTH-1:0]   epos_r, epos_nxt;
  logic [jsc_pkg::OFFSET_WIDTH-1:0]   cnt_r, cnt_nxt, pos;
  logic                               out_valid_r;
  logic [20:0]                        out_data_r;
  logic [3:0]                         fin_code;
  logic [jsc_pkg::OFFSET_WIDTH-1:0]   fin_pos;

  jsc_pkg::stack_op_t                 sop;
  logic [jsc_pkg::DEPTH_W-1:0]        depth;
  logic                               top, below;

  logic       acc, ws, dig, num_end, vstart, kstart, do_push, push_kind, do_pop, do_fin;
  logic       fail;
  logic [3:0] fail_code;
  logic [jsc_pkg::OFFSET_WIDTH-1:0] fail_pos;
  logic [7:0] b;
  jsc_pkg::mode_t fin_mode;

  jsc_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (sop),
    .depth (depth),
    .top   (top),
    .below (below)
  );

  assign in_tready = ~out_valid_r | out_tready;
  assign acc       = in_tvalid & in_tready;
  assign b         = in_tdata;
  assign pos       = cnt_r;
  assign ws        = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  assign dig       = (b >= 8'h30) && (b <= 8'h39);
  assign fin_mode  = (depth == '0) ? jsc_pkg::M_AFTER_ROOT :
                     (top ? jsc_pkg::M_ARR_AFTER : jsc_pkg::M_OBJ_AFTER);

  always_comb begin
    num_end = 1'b0;
    case (mode_r)
      jsc_pkg::M_NUM_INT:    num_end = !dig && b != 8'h2E && b != 8'h65 && b != 8'h45;
      jsc_pkg::M_NUM_FRAC:   num_end = !dig && b != 8'h65 && b != 8'h45;
      jsc_pkg::M_NUM_EXPDIG: num_end = !dig;
      default:               num_end = 1'b0;
    endcase
    eff = num_end ? fin_mode : mode_r;
  end

  always_comb begin
    mode_nxt  = eff;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    vstart    = 1'b0;
    kstart    = 1'b0;
    do_push   = 1'b0;
    push_kind = 1'b0;
    do_pop    = 1'b0;
    do_fin    = 1'b0;
    fail      = 1'b0;
    fail_code = jsc_pkg::E_OK;
    fail_pos  = pos;
    case (eff)
      jsc_pkg::M_ROOT: begin
        if (!ws) begin
          if (b == 8'h7B) begin
            do_push = 1'b1;
          end else begin
            fail = 1'b1; fail_code = jsc_pkg::E_ROOT;
          end
        end
      end
      jsc_pkg::M_OBJ_OPEN: begin
        if (!ws) begin
          if (b == 8'h7D) do_pop = 1'b1; else kstart = 1'b1;
        end
      end
      jsc_pkg::M_OBJ_COMMA: begin
        if (!ws) begin
          if (b == 8'h7D) begin
            fail = 1'b1; fail_code = jsc_pkg::E_TRAIL;
          end else begin
            kstart = 1'b1;
          end
        end
      end
      jsc_pkg::M_KEY_STR, jsc_pkg::M_VAL_STR: begin
        if (b == 8'h22) begin
          if (eff == jsc_pkg::M_KEY_STR) mode_nxt = jsc_pkg::M_OBJ_COLON; else do_fin = 1'b1;
        end else if (b == 8'h5C) begin
          mode_nxt = (eff == jsc_pkg::M_KEY_STR) ? jsc_pkg::M_KEY_ESC : jsc_pkg::M_VAL_ESC;
        end else if (b < 8'h20) begin
          fail = 1'b1; fail_code = jsc_pkg::E_CONTROL;
        end
      end
      jsc_pkg::M_KEY_ESC, jsc_pkg::M_VAL_ESC: begin
        if (b == 8'h22 || b == 8'h5C || b == 8'h2F || b == 8'h62 || b == 8'h66 ||
            b == 8'h6E || b == 8'h72 || b == 8'h74 || b == 8'h75) begin
          mode_nxt = (eff == jsc_pkg::M_KEY_ESC) ? jsc_pkg::M_KEY_STR : jsc_pkg::M_VAL_STR;
        end else begin
          fail = 1'b1; fail_code = jsc_pkg::E_ESCAPE;
        end
      end
      jsc_pkg::M_OBJ_COLON: begin
        if (!ws) begin
          if (b == 8'h3A) begin
            mode_nxt = jsc_pkg::M_OBJ_VALUE;
          end else begin
            fail = 1'b1; fail_code = jsc_pkg::E_COLON;
          end
        end
      end
      jsc_pkg::M_OBJ_VALUE: begin
        if (!ws) begin
          if (b == 8'h2C || b == 8'h7D) begin
            fail = 1'b1; fail_code = jsc_pkg::E_NOVAL;
          end else begin
            vstart = 1'b1;
          end
        end
      end
      jsc_pkg::M_OBJ_AFTER: begin
        if (!ws) begin
          if (b == 8'h7D) begin
            do_pop = 1'b1;
          end else if (b == 8'h2C) begin
            mode_nxt = jsc_pkg::M_OBJ_COMMA;
          end else begin
            fail = 1'b1; fail_code = jsc_pkg::E_SEP;
          end
        end
      end
      jsc_pkg::M_ARR_OPEN: begin
        if (!ws) begin
          if (b == 8'h5D) do_pop = 1'b1; else vstart = 1'b1;
        end
      end
      jsc_pkg::M_ARR_COMMA: begin
        if (!ws) begin
          if (b == 8'h5D) begin
            fail = 1'b1; fail_code = jsc_pkg::E_TRAIL;
          end else begin
            vstart = 1'b1;
          end
        end
      end
      jsc_pkg::M_ARR_AFTER: begin
        if (!ws) begin
          if (b == 8'h5D) begin
            do_pop = 1'b1;
          end else if (b == 8'h2C) begin
            mode_nxt = jsc_pkg::M_ARR_COMMA;
          end else begin
            fail = 1'b1; fail_code = jsc_pkg::E_SEP;
          end
        end
      end
      jsc_pkg::M_LIT: begin
        if (idx_r < jsc_pkg::lit_len(kind_r) && b == jsc_pkg::lit_char(kind_r, idx_r)) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r + 3'd1 >= jsc_pkg::lit_len(kind_r)) do_fin = 1'b1;
        end else begin
          fail      = 1'b1;
          fail_code = jsc_pkg::E_LITERAL;
          fail_pos  = (pos >= jsc_pkg::OFFSET_WIDTH'(idx_r)) ?
                      pos - jsc_pkg::OFFSET_WIDTH'(idx_r) : '0;
        end
      end
      jsc_pkg::M_NUM_SIGN, jsc_pkg::M_NUM_DOT, jsc_pkg::M_NUM_EXPSIGN: begin
        if (dig) begin
          if (eff == jsc_pkg::M_NUM_SIGN) mode_nxt = jsc_pkg::M_NUM_INT;
          else if (eff == jsc_pkg::M_NUM_DOT) mode_nxt = jsc_pkg::M_NUM_FRAC;
          else mode_nxt = jsc_pkg::M_NUM_EXPDIG;
        end else begin
          fail = 1'b1; fail_code = jsc_pkg::E_NUMBER;
        end
      end
      jsc_pkg::M_NUM_INT: begin
        if (b == 8'h2E) mode_nxt = jsc_pkg::M_NUM_DOT;
        else if (b == 8'h65 || b == 8'h45) mode_nxt = jsc_pkg::M_NUM_EXP;
      end
      jsc_pkg::M_NUM_FRAC: begin
        if (b == 8'h65 || b == 8'h45) mode_nxt = jsc_pkg::M_NUM_EXP;
      end
      jsc_pkg::M_NUM_EXP: begin
        if (b == 8'h2B || b == 8'h2D) begin
          mode_nxt = jsc_pkg::M_NUM_EXPSIGN;
        end else if (dig) begin
          mode_nxt = jsc_pkg::M_NUM_EXPDIG;
        end else begin
          fail = 1'b1; fail_code = jsc_pkg::E_NUMBER;
        end
      end
      jsc_pkg::M_AFTER_ROOT: begin
        if (!ws) begin
          fail = 1'b1; fail_code = jsc_pkg::E_AFTER;
        end
      end
      default: begin
        mode_nxt = eff;
      end
    endcase

    if (vstart) begin
      if (b == 8'h22) begin
        mode_nxt = jsc_pkg::M_VAL_STR;
      end else if (b == 8'h7B) begin
        do_push = 1'b1;
      end else if (b == 8'h5B) begin
        do_push = 1'b1; push_kind = 1'b1;
      end else if (b == 8'h74 || b == 8'h66 || b == 8'h6E) begin
        kind_nxt = (b == 8'h74) ? jsc_pkg::LIT_TRUE :
                   ((b == 8'h66) ? jsc_pkg::LIT_FALSE : jsc_pkg::LIT_NULL);
        idx_nxt  = 3'd1;
        mode_nxt = jsc_pkg::M_LIT;
      end else if (b == 8'h2D) begin
        mode_nxt = jsc_pkg::M_NUM_SIGN;
      end else if (dig) begin
        mode_nxt = jsc_pkg::M_NUM_INT;
      end else begin
        fail = 1'b1; fail_code = jsc_pkg::E_CHAR;
      end
    end
    if (kstart) begin
      if (b == 8'h22) begin
        mode_nxt = jsc_pkg::M_KEY_STR;
      end else begin
        fail = 1'b1; fail_code = jsc_pkg::E_KEY;
      end
    end
    if (do_push) begin
      if (depth == jsc_pkg::DEPTH_W'(jsc_pkg::MAX_DEPTH)) begin
        do_push = 1'b0; fail = 1'b1; fail_code = jsc_pkg::E_DEPTH;
      end else begin
        mode_nxt = push_kind ? jsc_pkg::M_ARR_OPEN : jsc_pkg::M_OBJ_OPEN;
      end
    end
    if (do_pop) begin
      if (depth <= jsc_pkg::DEPTH_W'(1)) mode_nxt = jsc_pkg::M_AFTER_ROOT;
      else mode_nxt = below ? jsc_pkg::M_ARR_AFTER : jsc_pkg::M_OBJ_AFTER;
    end
    if (do_fin) mode_nxt = fin_mode;
    if (fail) mode_nxt = jsc_pkg::M_ERR;
  end

  assign cnt_nxt  = (cnt_r == OFF_MAX) ? cnt_r : cnt_r + 1'b1;
  assign err_nxt  = fail ? fail_code : err_r;
  assign epos_nxt = fail ? fail_pos : epos_r;

  always_comb begin
    fin_code = err_nxt;
    fin_pos  = epos_nxt;
    case (mode_nxt)
      jsc_pkg::M_ERR, jsc_pkg::M_ROOT, jsc_pkg::M_AFTER_ROOT: begin
        fin_code = err_nxt;
      end
      jsc_pkg::M_NUM_SIGN, jsc_pkg::M_NUM_DOT, jsc_pkg::M_NUM_EXP,
      jsc_pkg::M_NUM_EXPSIGN: begin
        fin_code = jsc_pkg::E_NUMBER;
        fin_pos  = cnt_nxt;
      end
      jsc_pkg::M_LIT: begin
        fin_code = jsc_pkg::E_LITERAL;
        fin_pos  = (cnt_nxt >= jsc_pkg::OFFSET_WIDTH'(idx_nxt)) ?
                   cnt_nxt - jsc_pkg::OFFSET_WIDTH'(idx_nxt) : '0;
      end
      default: begin
        fin_code = jsc_pkg::E_EARLY;
        fin_pos  = cnt_nxt;
      end
    endcase
  end

  always_comb begin
    sop.clear = acc & in_tlast;
    sop.push  = acc & do_push;
    sop.pop   = acc & do_pop;
    sop.kind  = push_kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsc_pkg::M_ROOT;
      kind_r <= '0;
      idx_r  <= '0;
      err_r  <= jsc_pkg::E_OK;
      epos_r <= '0;
      cnt_r  <= '0;
    end else if (acc) begin
      if (in_tlast) begin
        mode_r <= jsc_pkg::M_ROOT;
        kind_r <= '0;
        idx_r  <= '0;
        err_r  <= jsc_pkg::E_OK;
        epos_r <= '0;
        cnt_r  <= '0;
      end else begin
        mode_r <= mode_nxt;
        kind_r <= kind_nxt;
        idx_r  <= idx_nxt;
        err_r  <= err_nxt;
        epos_r <= epos_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_tlast) begin
      out_data_r <= {(fin_code == jsc_pkg::E_OK) ? 16'd0 : fin_pos[15:0], fin_code,
                     fin_code == jsc_pkg::E_OK};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth <= jsc_pkg::DEPTH_W'(jsc_pkg::MAX_DEPTH))
    else $error("nesting depth beyond the stack size");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == jsc_pkg::M_ERR) |-> (err_r != jsc_pkg::E_OK))
    else $error("error mode without a latched code");

  a_root_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == jsc_pkg::M_ROOT) |-> (depth == '0))
    else $error("stack not empty while waiting for the root");

  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> out_tvalid)
    else $error("no verdict after the last byte");

endmodule
